>>> rtl/core/stable_priority_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// stable_priority_queue_unit_macros.svh
// assertion macros used by the priority queue top level
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the priority queue cell row and its top level
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int PRIO_W  = 16;
    localparam int TAG_W   = 16;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
    } t_entry;

    // broadcast to every cell for one operation
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
    } t_ctl;

endpackage

>>> rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: holds, takes the new word, or shifts from a
// neighbor
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic            i_clk,
    input  spq_pkg::t_ctl   i_ctl,
    input  logic            i_valid,
    input  logic            i_left_keep,
    input  spq_pkg::t_entry i_left,
    input  spq_pkg::t_entry i_right,
    output spq_pkg::t_entry o_ent,
    output logic            o_keep
);
    import spq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;

    // equal priority stays ahead of the new word
    assign o_keep = i_valid && (r_ent.prio >= i_ctl.prio);
    assign o_ent  = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.ins) begin
            if (!o_keep) begin
                if (i_left_keep) begin
                    n_ent.prio = i_ctl.prio;
                    n_ent.tag  = i_ctl.tag;
                end else begin
                    n_ent = i_left;
                end
            end
        end else if (i_ctl.rem) begin
            n_ent = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

>>> rtl/core/stable_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue kept sorted in a row of cells, highest priority at
// cell 0; equal priorities leave in arrival order. For every command, whatever
// the fill level, the cell row updates at the accepting edge,
// and in the next cycle o_valid shows the result while busy holds off the
// next command. The receiver cannot stall: each result is on the ports for
// that one cycle only. An insert into a full queue is dropped with status
// full, a remove from an empty queue returns status empty.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_unit_macros.svh"

module stable_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_operation,
    input  logic signed [spq_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic        [spq_pkg::TAG_W-1:0]     i_data_tag,
    output logic                                 o_valid,
    output logic        [spq_pkg::STAT_W-1:0]    o_status,
    output logic signed [spq_pkg::PRIO_W-1:0]    o_removed_priority,
    output logic        [spq_pkg::TAG_W-1:0]     o_removed_data,
    output logic        [spq_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                                 o_head_valid,
    output logic signed [spq_pkg::PRIO_W-1:0]    o_head_priority,
    output logic        [spq_pkg::TAG_W-1:0]     o_head_data
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic                r_valid;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [STAT_W-1:0]   r_status;
    logic [STAT_W-1:0]   n_status;
    t_entry              r_removed;
    t_entry              n_removed;

    logic                accept;
    logic                empty;
    logic                full;
    t_ctl                ctl;
    t_entry              ent  [CAPACITY];
    logic                keep [CAPACITY];
    t_entry              zero_ent;

    assign accept   = start && !busy;
    assign busy     = r_valid;
    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(CAPACITY));
    assign zero_ent = '0;

    always_comb begin
        ctl.ins  = accept && (i_operation == OP_INSERT) && !full;
        ctl.rem  = accept && (i_operation == OP_REMOVE) && !empty;
        ctl.prio = i_priority_req;
        ctl.tag  = i_data_tag;
    end

    always_comb begin
        n_count   = r_count;
        n_status  = ST_OK;
        n_removed = '0;
        if (i_operation == OP_INSERT) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count   = r_count - 1'b1;
                n_removed = ent[0];
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic   left_keep;
            t_entry left_ent;
            t_entry right_ent;

            if (gi == 0) begin : g_first
                assign left_keep = 1'b1;
                assign left_ent  = zero_ent;
            end else begin : g_mid
                assign left_keep = keep[gi-1];
                assign left_ent  = ent[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_ent = zero_ent;
            end else begin : g_inner
                assign right_ent = ent[gi+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_valid     (CW'(gi) < r_count),
                .i_left_keep (left_keep),
                .i_left      (left_ent),
                .i_right     (right_ent),
                .o_ent       (ent[gi]),
                .o_keep      (keep[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_removed_priority = r_removed.prio;
    assign o_removed_data     = r_removed.tag;
    assign o_entry_count      = COUNT_W'(r_count);
    assign o_head_valid       = !empty;
    assign o_head_priority    = empty ? '0 : ent[0].prio;
    assign o_head_data        = empty ? '0 : ent[0].tag;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `SPQ_ASSERT_NEXT(a_result_follows, accept, o_valid && busy, "no result after command")
    `SPQ_ASSERT_NEXT(a_count_idle, !accept, $stable(r_count), "count moved without command")
    `SPQ_ASSERT_NEXT(a_empty_remove, accept && (i_operation == OP_REMOVE) && empty,
        (o_status == ST_EMPTY) && !o_head_valid, "empty remove not flagged")

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Runs insert and remove commands through stable_priority_queue_unit. A
// sorted-array model of the queue predicts every result, and each result
// strobe is checked field by field. The directed opening covers the priority
// extremes, equal priorities, and remove from empty and insert into full.
// The random part then runs randomly chosen fill, drain and mixed phases.
// ----------------------------------------------------------------------------
module testbench;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int RANDOM_WORDS   = 650;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        logic                     op;
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
    } t_command;

    typedef struct {
        logic        [STAT_W-1:0]  status;
        logic signed [PRIO_W-1:0]  rem_prio;
        logic        [TAG_W-1:0]   rem_tag;
        logic        [COUNT_W-1:0] count;
        logic                      head_valid;
        logic signed [PRIO_W-1:0]  head_prio;
        logic        [TAG_W-1:0]   head_tag;
    } t_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_operation = OP_INSERT;
    logic signed [PRIO_W-1:0]  i_priority_req = '0;
    logic        [TAG_W-1:0]   i_data_tag = '0;
    logic                      o_valid;
    logic        [STAT_W-1:0]  o_status;
    logic signed [PRIO_W-1:0]  o_removed_priority;
    logic        [TAG_W-1:0]   o_removed_data;
    logic        [COUNT_W-1:0] o_entry_count;
    logic                      o_head_valid;
    logic signed [PRIO_W-1:0]  o_head_priority;
    logic        [TAG_W-1:0]   o_head_data;

    t_command pending_commands[$];
    t_result  expected_results[$];
    t_command current_command;

    // queue model: slot 0 is the head
    t_entry sorted_entries[0:QUEUE_DEPTH-1];
    int     fill_level = 0;

    int mismatch_count = 0;
    int accepted_count = 0;
    int total_commands = 0;
    int burst_left = 1;
    int gap_left = 0;
    int idle_cycles = 0;

    stable_priority_queue_unit #(
        .CAPACITY(QUEUE_DEPTH)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_priority_req     (i_priority_req),
        .i_data_tag         (i_data_tag),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_removed_priority (o_removed_priority),
        .o_removed_data     (o_removed_data),
        .o_entry_count      (o_entry_count),
        .o_head_valid       (o_head_valid),
        .o_head_priority    (o_head_priority),
        .o_head_data        (o_head_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result apply_command(t_command cmd);
        t_result r;
        int pos;
        int i;
        r.status = ST_OK;
        r.rem_prio = '0;
        r.rem_tag = '0;
        if (cmd.op == OP_INSERT) begin
            if (fill_level >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // new entry goes behind every entry of equal or higher priority
                pos = 0;
                while (pos < fill_level &&
                       $signed(sorted_entries[pos].prio) >= $signed(cmd.prio))
                    pos++;
                for (i = fill_level; i > pos; i--)
                    sorted_entries[i] = sorted_entries[i-1];
                sorted_entries[pos].prio = cmd.prio;
                sorted_entries[pos].tag = cmd.tag;
                fill_level++;
            end
        end else begin
            if (fill_level == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.rem_prio = sorted_entries[0].prio;
                r.rem_tag = sorted_entries[0].tag;
                for (i = 1; i < fill_level; i++)
                    sorted_entries[i-1] = sorted_entries[i];
                fill_level--;
            end
        end
        r.count = fill_level[COUNT_W-1:0];
        r.head_valid = (fill_level > 0);
        r.head_prio = (fill_level > 0) ? sorted_entries[0].prio : '0;
        r.head_tag = (fill_level > 0) ? sorted_entries[0].tag : '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(string what, int got, int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    task automatic push_command(logic op, logic signed [PRIO_W-1:0] prio,
                                logic [TAG_W-1:0] tag);
        t_command cmd;
        cmd.op = op;
        cmd.prio = prio;
        cmd.tag = tag;
        pending_commands.push_back(cmd);
    endtask

    // narrow values make equal priorities common
    function automatic logic signed [PRIO_W-1:0] random_priority();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return PRIO_W'($signed($urandom_range(0, 6)) - 3);
        else if (pick == 4)
            case ($urandom_range(0, 3))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shffff;
            endcase
        return PRIO_W'($urandom);
    endfunction

    // driver: holds a word until taken, then bursts and gaps at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(apply_command(current_command));
                accepted_count++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_commands.size() > 0) begin
                    current_command = pending_commands.pop_front();
                    i_operation <= current_command.op;
                    i_priority_req <= current_command.prio;
                    i_data_tag <= current_command.tag;
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none pending, status", o_status, 0);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", o_status, want.status);
                    check_field("removed_priority", o_removed_priority, want.rem_prio);
                    check_field("removed_data", o_removed_data, want.rem_tag);
                    check_field("entry_count", o_entry_count, want.count);
                    check_field("head_valid", o_head_valid, want.head_valid);
                    check_field("head_priority", o_head_priority, want.head_prio);
                    check_field("head_data", o_head_data, want.head_tag);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int i;
        int phase_len;
        int insert_pct;

        // remove from empty, with the ignored fields set
        push_command(OP_REMOVE, 16'sh7fff, 16'hffff);
        // extremes and equal priorities, filled to capacity
        push_command(OP_INSERT, 16'sh0000, 16'h1111);
        push_command(OP_INSERT, 16'sh7fff, 16'hffff);
        push_command(OP_INSERT, 16'sh8000, 16'h0000);
        push_command(OP_INSERT, 16'sh0000, 16'h2222);
        push_command(OP_INSERT, 16'shffff, 16'h0001);
        push_command(OP_INSERT, 16'sh0001, 16'h8000);
        push_command(OP_INSERT, 16'sh7fff, 16'h0fff);
        push_command(OP_INSERT, 16'sh8000, 16'habcd);
        for (i = 0; i < 8; i++)
            push_command(OP_INSERT, PRIO_W'($signed($urandom_range(0, 2)) - 1),
                         TAG_W'($urandom));
        // insert into a full queue is dropped
        push_command(OP_INSERT, 16'sh3039, 16'h5a5a);
        for (i = 0; i < 4; i++)
            push_command(OP_REMOVE, PRIO_W'($urandom), TAG_W'($urandom));

        // fill, drain and mixed phases so full and empty both recur
        i = 0;
        while (i < RANDOM_WORDS) begin
            phase_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: insert_pct = 80;
                1: insert_pct = 20;
                default: insert_pct = 50;
            endcase
            repeat (phase_len) begin
                if ($urandom_range(1, 100) <= insert_pct)
                    push_command(OP_INSERT, random_priority(), TAG_W'($urandom));
                else
                    push_command(OP_REMOVE, PRIO_W'($urandom), TAG_W'($urandom));
                i++;
            end
        end
        total_commands = pending_commands.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_commands || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch("results left pending", expected_results.size(), 0);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue_unit.sv
sim/testbench.sv
